/* rtl/tct_pkg.sv */
// Package for the TCP connection tracker: codes, phase encodings, entry type.
// No dependencies.
package tct_pkg;

    localparam int DEFAULT_MAX_CONNECTIONS = 64;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_TRACK = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] SIDE_IN  = 2'd1;
    localparam logic [1:0] SIDE_OUT = 2'd2;
    localparam logic [1:0] SIDE_ANY = 2'd3;

    localparam logic [3:0] PH_PRESYN = 4'd0;
    localparam logic [3:0] PH_SYN    = 4'd1;
    localparam logic [3:0] PH_SYNACK = 4'd2;
    localparam logic [3:0] PH_EST    = 4'd3;
    localparam logic [3:0] PH_FIN1   = 4'd4;
    localparam logic [3:0] PH_A_ACK  = 4'd5;
    localparam logic [3:0] PH_A_FIN2 = 4'd6;
    localparam logic [3:0] PH_B_FIN2 = 4'd7;
    localparam logic [3:0] PH_B_ACK  = 4'd8;

    localparam logic [2:0] VERD_VALID    = 3'd0;
    localparam logic [2:0] VERD_INVALID  = 3'd1;
    localparam logic [2:0] VERD_ENDED    = 3'd2;
    localparam logic [2:0] VERD_NOTFOUND = 3'd3;
    localparam logic [2:0] VERD_FULL     = 3'd4;

    typedef struct packed {
        logic [31:0] int_ip;
        logic [15:0] int_port;
        logic [31:0] ext_ip;
        logic [15:0] ext_port;
        logic [3:0]  phase;
        logic [1:0]  side;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_SHIFT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic [3:0] phase;
        logic [1:0] side;
    } check_t;

    function automatic logic [1:0] other_side(input logic [1:0] d);
        return (d == SIDE_IN) ? SIDE_OUT : SIDE_IN;
    endfunction

    function automatic logic [1:0] public_of(input logic [3:0] ph);
        case (ph)
            PH_PRESYN:         return 2'd0;
            PH_SYN, PH_SYNACK: return 2'd1;
            PH_EST:            return 2'd2;
            default:           return 2'd3;
        endcase
    endfunction

endpackage

/* rtl/tcp_connection_tracker_top.sv */
// Top level of the TCP connection tracker: sequencer around the table memory.
// Depends on tct_pkg, tct_table, tct_check.
//
// Use: one command beat on s_* (add, track, clear) yields one result beat on
// m_* (found, verdict, public_state, entry_count). Entries live in a
// single-port-read memory in insertion order.
// Add, clear and the no-op command go from the scan state straight to the
// output state. Track scans entries one per cycle through the memory read
// port; on a hit it rereads the hit entry for the check state, and a miss
// reports not found once every entry held has been read. When the entry
// ends, the later entries are moved up one place, one entry per cycle (read
// one, write the one before).
// Throughput is one item at a time: s_ready is high only in the idle state, so
// the block passes through idle between a result beat and the next command beat.
// Reset empties the table (count to zero); memory contents stay undefined and
// are never used above the count. No clearing pass is needed.
// When the receiver stalls, the result holds in the output register and no
// new beat is accepted until it is taken.
module tcp_connection_tracker_top import tct_pkg::*; #(
    parameter int MAX_CONNECTIONS = DEFAULT_MAX_CONNECTIONS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [1:0]  s_direction,
    input  logic [31:0] s_src_ip,
    input  logic [15:0] s_src_port,
    input  logic [31:0] s_dst_ip,
    input  logic [15:0] s_dst_port,
    input  logic        s_flag_syn,
    input  logic        s_flag_ack,
    input  logic        s_flag_fin,
    input  logic        s_flag_rst,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [2:0]  m_verdict,
    output logic [1:0]  m_public_state,
    output logic [6:0]  m_entry_count
);
    localparam int AW = $clog2(MAX_CONNECTIONS);
    localparam int CW = $clog2(MAX_CONNECTIONS + 1);
    localparam logic [CW-1:0] CMAX = CW'(MAX_CONNECTIONS);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // index of entry being read
    logic          rd_pend_reg, rd_pend_next;
    logic [1:0]    cmd_reg;
    logic [1:0]    dir_reg;
    logic [31:0]   iip_reg, eip_reg;
    logic [15:0]   iport_reg, eport_reg;
    logic          syn_reg, ack_reg, fin_reg, rst_reg;
    logic          found_reg, found_next;
    logic [2:0]    verd_reg, verd_next;
    logic [1:0]    pub_reg, pub_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;
    check_t        chk;
    logic [1:0]    in_dir;
    logic          hit;

    assign in_dir = (s_direction == SIDE_OUT) ? SIDE_OUT : SIDE_IN;

    tct_table #(.DEPTH(MAX_CONNECTIONS), .AW(AW)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    tct_check u_check (
        .phase(rdata.phase), .side(rdata.side), .dir(dir_reg),
        .syn(syn_reg), .ack(ack_reg), .fin(fin_reg), .rst(rst_reg), .res(chk)
    );

    assign hit = (rdata.int_ip == iip_reg) && (rdata.ext_ip == eip_reg)
              && (rdata.int_port == iport_reg || rdata.int_port == 16'd0
                  || iport_reg == 16'd0)
              && (rdata.ext_port == eport_reg || rdata.ext_port == 16'd0
                  || eport_reg == 16'd0);

    // Latch the command beat.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
            dir_reg <= in_dir;
            iip_reg   <= (in_dir == SIDE_OUT) ? s_src_ip   : s_dst_ip;
            iport_reg <= (in_dir == SIDE_OUT) ? s_src_port : s_dst_port;
            eip_reg   <= (in_dir == SIDE_OUT) ? s_dst_ip   : s_src_ip;
            eport_reg <= (in_dir == SIDE_OUT) ? s_dst_port : s_src_port;
            syn_reg <= s_flag_syn;
            ack_reg <= s_flag_ack;
            fin_reg <= s_flag_fin;
            rst_reg <= s_flag_rst;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
        end
        found_reg <= found_next;
        verd_reg  <= verd_next;
        pub_reg   <= pub_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        found_next   = found_reg;
        verd_next    = verd_reg;
        pub_next     = pub_reg;
        we           = 1'b0;
        waddr        = idx_reg[AW-1:0];
        wdata        = rdata;
        raddr        = idx_reg[AW-1:0];
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                idx_next   = '0;
                found_next = 1'b0;
                verd_next  = VERD_VALID;
                pub_next   = 2'd0;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                case (cmd_reg)
                    CMD_ADD: begin
                        if (count_reg >= CMAX) begin
                            verd_next = VERD_FULL;
                        end else begin
                            we    = 1'b1;
                            waddr = count_reg[AW-1:0];
                            wdata = '{iip_reg, iport_reg, eip_reg, eport_reg,
                                      PH_PRESYN, SIDE_ANY};
                            count_next = count_reg + CW'(1);
                        end
                        state_next = ST_OUT;
                    end
                    CMD_TRACK: begin
                        if (rd_pend_reg && hit) begin
                            // Read data belongs to idx-1; step back and reread it
                            // so the check stage sees the hit entry.
                            raddr      = idx_reg[AW-1:0] - AW'(1);
                            idx_next   = idx_reg - CW'(1);
                            state_next = ST_CHECK;
                        end else if (idx_reg >= count_reg) begin
                            verd_next  = VERD_NOTFOUND;
                            state_next = ST_OUT;
                        end else begin
                            raddr        = idx_reg[AW-1:0];
                            idx_next     = idx_reg + CW'(1);
                            rd_pend_next = 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        count_next = '0;
                        state_next = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_CHECK: begin
                // rdata holds the hit entry (reread in the hit cycle).
                found_next = 1'b1;
                verd_next  = chk.verdict;
                if (chk.verdict == VERD_ENDED) begin
                    pub_next     = public_of(rdata.phase);
                    raddr        = idx_reg[AW-1:0] + AW'(1);
                    idx_next     = idx_reg + CW'(1);
                    rd_pend_next = 1'b1;
                    state_next   = ST_SHIFT;
                end else begin
                    pub_next   = public_of(chk.phase);
                    we         = 1'b1;
                    waddr      = idx_reg[AW-1:0];
                    wdata      = rdata;
                    wdata.phase = chk.phase;
                    wdata.side  = chk.side;
                    state_next = ST_OUT;
                end
            end
            ST_SHIFT: begin
                // rdata holds entry idx; move it to idx-1 while in range.
                if (idx_reg < count_reg) begin
                    we    = 1'b1;
                    waddr = idx_reg[AW-1:0] - AW'(1);
                    wdata = rdata;
                end
                if (idx_reg + CW'(1) < count_reg) begin
                    raddr    = idx_reg[AW-1:0] + AW'(1);
                    idx_next = idx_reg + CW'(1);
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold the result registers on the output while ST_OUT waits for m_ready.
    assign m_valid        = (state_reg == ST_OUT);
    assign m_found        = found_reg;
    assign m_verdict      = verd_reg;
    assign m_public_state = pub_reg;
    assign m_entry_count  = 7'(count_reg);

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CMAX;
    endproperty
    assert property (p_count_bound) else $error("entry count above capacity");

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) s_ready |-> !m_valid;
    endproperty
    assert property (p_ready_idle) else $error("input ready while result pending");

    property p_shift_drops_one;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == ST_SHIFT && state_next == ST_OUT)
            |=> count_reg == $past(count_reg) - CW'(1);
    endproperty
    assert property (p_shift_drops_one) else $error("removal did not drop one entry");
endmodule

/* rtl/tct_check.sv */
// TCP phase check: next phase, expected side and verdict for one entry.
// Depends on tct_pkg.
module tct_check import tct_pkg::*; (
    input  logic [3:0] phase,
    input  logic [1:0] side,
    input  logic [1:0] dir,
    input  logic       syn,
    input  logic       ack,
    input  logic       fin,
    input  logic       rst,
    output check_t     res
);
    always_comb begin
        res.verdict = VERD_INVALID;
        res.phase   = phase;
        res.side    = side;
        if (rst) begin
            res.verdict = VERD_ENDED;
        end else if ((dir & side) != 2'd0) begin
            case (phase)
                PH_PRESYN: if (syn && !ack) begin
                    res = '{VERD_VALID, PH_SYN, other_side(dir)};
                end
                PH_SYN: if (syn && ack) begin
                    res = '{VERD_VALID, PH_SYNACK, other_side(dir)};
                end
                PH_SYNACK: if (ack) begin
                    res = '{VERD_VALID, PH_EST, SIDE_ANY};
                end
                PH_EST: begin
                    res.verdict = VERD_VALID;
                    if (fin) begin
                        res.phase = PH_FIN1;
                        res.side  = other_side(dir);
                    end
                end
                PH_FIN1: begin
                    if (fin && ack) res = '{VERD_VALID, PH_A_FIN2, other_side(dir)};
                    else if (ack)   res = '{VERD_VALID, PH_A_ACK, dir};
                    else if (fin)   res = '{VERD_VALID, PH_B_FIN2, SIDE_ANY};
                end
                PH_A_ACK: if (fin) begin
                    res = '{VERD_VALID, PH_A_FIN2, other_side(dir)};
                end
                PH_A_FIN2, PH_B_ACK: if (ack) begin
                    res.verdict = VERD_ENDED;
                end
                PH_B_FIN2: if (ack) begin
                    res = '{VERD_VALID, PH_B_ACK, other_side(dir)};
                end
                default: res.verdict = VERD_INVALID;
            endcase
        end
    end
endmodule

/* rtl/tct_table.sv */
// Connection table memory: one write port, one registered read port.
// Depends on tct_pkg.
module tct_table import tct_pkg::*; #(
    parameter int DEPTH = DEFAULT_MAX_CONNECTIONS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);
    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

/* test/tcp_connection_tracker_top_test.sv */
// Testbench for tcp_connection_tracker_top: directed and random packets checked
// against an in-bench model of the connection table. Depends on tct_pkg.
module tcp_connection_tracker_top_test;
    import tct_pkg::*;

    localparam int DEPTH = DEFAULT_MAX_CONNECTIONS;

    typedef struct packed {
        logic        found;
        logic [2:0]  verdict;
        logic [1:0]  public_state;
        logic [6:0]  entry_count;
    } outcome_t;

    // Model copy of the connection table, kept packed in insertion order.
    entry_t table_q[$];

    outcome_t    pending_q[$];
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_CLEAR;
    logic [1:0]  s_direction = SIDE_IN;
    logic [31:0] s_src_ip = '0;
    logic [15:0] s_src_port = '0;
    logic [31:0] s_dst_ip = '0;
    logic [15:0] s_dst_port = '0;
    logic        s_flag_syn = 1'b0;
    logic        s_flag_ack = 1'b0;
    logic        s_flag_fin = 1'b0;
    logic        s_flag_rst = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_found;
    logic [2:0]  m_verdict;
    logic [1:0]  m_public_state;
    logic [6:0]  m_entry_count;

    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    int hold_req = 0;   // bumped by a test to request a long hold-off
    int hold_seen = 0;  // last request taken by the stall process

    // Pool of known connections so random tracking hits real entries.
    logic [31:0] pool_ip [0:7];
    logic [15:0] pool_port [0:7];

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #(12 * 5000000);
        $display("CHECK FAILED");
        $finish;
    end

    tcp_connection_tracker_top uut (.*);

    function automatic logic [1:0] opposite(input logic [1:0] d);
        return (d == SIDE_IN) ? SIDE_OUT : SIDE_IN;
    endfunction

    function automatic logic [1:0] phase_class(input logic [3:0] ph);
        if (ph == PH_PRESYN) return 2'd0;
        if (ph == PH_SYN || ph == PH_SYNACK) return 2'd1;
        if (ph == PH_EST) return 2'd2;
        return 2'd3;
    endfunction

    function automatic bit port_ok(input logic [15:0] a, input logic [15:0] b);
        return a == b || a == 16'd0 || b == 16'd0;
    endfunction

    // Advance the model for one packet and return its outcome.
    function automatic outcome_t track_connection(
        input logic [1:0] cmd, input logic [1:0] dir_in,
        input logic [31:0] sip, input logic [15:0] sport,
        input logic [31:0] dip, input logic [15:0] dport,
        input logic syn, input logic ack, input logic fin, input logic rst);
        outcome_t r;
        entry_t e;
        logic [1:0] dir;
        logic [31:0] iip, eip;
        logic [15:0] iport, eport;
        int hit;
        r = '0;
        dir = (dir_in == SIDE_OUT) ? SIDE_OUT : SIDE_IN;
        if (dir == SIDE_OUT) begin
            iip = sip; iport = sport; eip = dip; eport = dport;
        end else begin
            iip = dip; iport = dport; eip = sip; eport = sport;
        end
        if (cmd == CMD_ADD) begin
            if (table_q.size() >= DEPTH) begin
                r.verdict = VERD_FULL;
            end else begin
                e.int_ip = iip; e.int_port = iport;
                e.ext_ip = eip; e.ext_port = eport;
                e.phase = PH_PRESYN; e.side = SIDE_ANY;
                table_q.push_back(e);
            end
        end else if (cmd == CMD_TRACK) begin
            hit = -1;
            foreach (table_q[i])
                if (hit < 0 && table_q[i].int_ip == iip && port_ok(table_q[i].int_port, iport)
                    && table_q[i].ext_ip == eip && port_ok(table_q[i].ext_port, eport))
                    hit = i;
            if (hit < 0) begin
                r.verdict = VERD_NOTFOUND;
            end else begin
                r.found = 1'b1;
                e = table_q[hit];
                r.verdict = VERD_INVALID;
                if (rst) r.verdict = VERD_ENDED;
                else if ((dir & e.side) != 2'd0) begin
                    case (e.phase)
                        PH_PRESYN: if (syn && !ack) begin
                            e.phase = PH_SYN; e.side = opposite(dir); r.verdict = VERD_VALID;
                        end
                        PH_SYN: if (syn && ack) begin
                            e.phase = PH_SYNACK; e.side = opposite(dir); r.verdict = VERD_VALID;
                        end
                        PH_SYNACK: if (ack) begin
                            e.phase = PH_EST; e.side = SIDE_ANY; r.verdict = VERD_VALID;
                        end
                        PH_EST: begin
                            r.verdict = VERD_VALID;
                            if (fin) begin
                                e.phase = PH_FIN1; e.side = opposite(dir);
                            end
                        end
                        PH_FIN1: begin
                            r.verdict = VERD_VALID;
                            if (fin && ack) begin
                                e.phase = PH_A_FIN2; e.side = opposite(dir);
                            end else if (ack) begin
                                e.phase = PH_A_ACK; e.side = dir;
                            end else if (fin) begin
                                e.phase = PH_B_FIN2; e.side = SIDE_ANY;
                            end else r.verdict = VERD_INVALID;
                        end
                        PH_A_ACK: if (fin) begin
                            e.phase = PH_A_FIN2; e.side = opposite(dir); r.verdict = VERD_VALID;
                        end
                        PH_A_FIN2, PH_B_ACK: if (ack) r.verdict = VERD_ENDED;
                        PH_B_FIN2: if (ack) begin
                            e.phase = PH_B_ACK; e.side = opposite(dir); r.verdict = VERD_VALID;
                        end
                        default: ;
                    endcase
                end
                r.public_state = phase_class(e.phase);
                // Drop an ended entry and close the gap.
                if (r.verdict == VERD_ENDED) table_q.delete(hit);
                else table_q[hit] = e;
            end
        end else if (cmd == CMD_CLEAR) begin
            table_q.delete();
        end
        r.entry_count = 7'(table_q.size());
        return r;
    endfunction

    // Offer one beat, hold it until accepted, then predict its outcome.
    // Valid stays high after acceptance; the next call or wait_drained drops it.
    task automatic send_packet(input logic [1:0] cmd, input logic [1:0] dir,
        input logic [31:0] sip, input logic [15:0] sport,
        input logic [31:0] dip, input logic [15:0] dport,
        input logic syn, input logic ack, input logic fin, input logic rst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd; s_direction <= dir;
        s_src_ip <= sip; s_src_port <= sport; s_dst_ip <= dip; s_dst_port <= dport;
        s_flag_syn <= syn; s_flag_ack <= ack; s_flag_fin <= fin; s_flag_rst <= rst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_q.push_back(track_connection(cmd, dir, sip, sport, dip, dport,
                                             syn, ack, fin, rst));
    endtask

    // Send a packet for pool connection k; the outbound side holds the internal end.
    task automatic send_flow(input int k, input logic [1:0] cmd, input logic [1:0] dir,
        input logic [3:0] flags);
        if (dir == SIDE_OUT)
            send_packet(cmd, dir, pool_ip[k], pool_port[k], ~pool_ip[k],
                        pool_port[k] + 16'd1, flags[3], flags[2], flags[1], flags[0]);
        else
            send_packet(cmd, dir, ~pool_ip[k], pool_port[k] + 16'd1, pool_ip[k],
                        pool_port[k], flags[3], flags[2], flags[1], flags[0]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    // Receiver stall: random stall and forced hold-off counted in cycles.
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_off <= 400;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat");
            end else begin
                want = pending_q.pop_front();
                if ({m_found, m_verdict, m_public_state, m_entry_count} !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp found %0d verdict %0d state %0d ",
                                  "count %0d, got %0d %0d %0d %0d"},
                                 want.found, want.verdict, want.public_state,
                                 want.entry_count, m_found, m_verdict,
                                 m_public_state, m_entry_count);
                end
            end
        end
    end

    // Walk a full handshake and one teardown path (fin1, b-fin2, b-ack), plus reset and odd packets.
    task automatic test_directed();
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b1000);          // empty table: not found
        send_flow(0, CMD_ADD, SIDE_OUT, 4'b0000);
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b0100);          // presyn ack: invalid
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b1000);          // syn
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b1100);          // wrong side
        send_flow(0, CMD_TRACK, SIDE_IN, 4'b1100);           // syn-ack
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b0100);          // established
        send_flow(0, CMD_TRACK, 2'd3, 4'b0000);              // odd direction as inbound
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b0010);          // fin1
        send_flow(0, CMD_TRACK, SIDE_IN, 4'b0000);           // fin1 nothing: invalid
        send_flow(0, CMD_TRACK, SIDE_IN, 4'b0010);           // b-fin2
        send_flow(0, CMD_TRACK, SIDE_OUT, 4'b0100);          // b-ack
        send_flow(0, CMD_TRACK, SIDE_IN, 4'b0100);           // ended
        send_flow(1, CMD_ADD, SIDE_IN, 4'b0000);
        send_flow(2, CMD_ADD, SIDE_IN, 4'b0000);
        send_packet(CMD_TRACK, SIDE_OUT, pool_ip[2], 16'd0, ~pool_ip[2], 16'd0,
                    1'b0, 1'b0, 1'b0, 1'b1);                 // wildcard ports, reset
        send_packet(2'd3, 2'd0, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_packet(CMD_TRACK, SIDE_IN, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, 1'b1);
        // Fill past capacity with extreme addresses.
        repeat (DEPTH + 1)
            send_packet(CMD_ADD, SIDE_OUT, '1, '1, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_packet(CMD_TRACK, SIDE_OUT, '1, '1, '0, '0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_packet(CMD_CLEAR, SIDE_IN, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed flows on a small pool, with random flags as noise.
    task automatic test_random(input int count);
        int k, r;
        logic [3:0] fl;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(7);
            r = $urandom_range(99);
            fl = 4'($urandom);
            if (r < 12) send_flow(k, CMD_ADD, 2'($urandom_range(2, 1)), 4'b0000);
            else if (r < 14) send_packet(CMD_CLEAR, 2'($urandom_range(3)), $urandom,
                                         16'($urandom), $urandom, 16'($urandom),
                                         fl[3], fl[2], fl[1], fl[0]);
            else if (r < 20) send_packet(2'($urandom_range(3)), 2'($urandom_range(3)),
                                         $urandom, 16'($urandom), $urandom,
                                         16'($urandom), fl[3], fl[2], fl[1], fl[0]);
            else if (r < 28) send_flow(k, CMD_TRACK, 2'($urandom_range(2, 1)), fl);
            else begin
                // Pick flags that suit the usual next step; rst is rare.
                case ($urandom_range(4))
                    0: fl = 4'b1000;
                    1: fl = 4'b1100;
                    2: fl = 4'b0100;
                    3: fl = 4'b0010;
                    default: fl = 4'b0110;
                endcase
                if ($urandom_range(30) == 0) fl[0] = 1'b1;
                send_flow(k, CMD_TRACK, 2'($urandom_range(2, 1)), fl);
            end
        end
        wait_drained();
    endtask

    // Stall the receiver long enough that the block backs up its input.
    task automatic test_backpressure();
        hold_req <= hold_req + 1;
        for (int k = 0; k < 6; k++) send_flow(k, CMD_ADD, SIDE_OUT, 4'b0000);
        for (int k = 0; k < 6; k++) send_flow(k, CMD_TRACK, SIDE_OUT, 4'b1000);
        wait_drained();
    endtask

    initial begin
        for (int k = 0; k < 8; k++) begin
            pool_ip[k] = $urandom;
            pool_port[k] = (k == 7) ? 16'd0 : 16'($urandom);
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_random(500);
        send_idle_pct = 63;
        test_random(500);
        send_idle_pct = 0; recv_stall_pct = 63;
        test_random(500);
        send_idle_pct = 34; recv_stall_pct = 34;
        test_random(500);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && pending_q.size() == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end
endmodule
